/* rtl/fcta_pkg.sv */
`timescale 1ns / 1ps

package fcta_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 4096;

  localparam int unsigned SC_W   = 13;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned LINK_W = 16;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;

  localparam logic [SC_W-1:0]   SECTOR_COUNT_RST = 13'd4096;
  localparam logic [LINK_W-1:0] LINK_END         = 16'hFFFF;

  localparam logic [OP_W-1:0] OP_READ = 2'd0;
  localparam logic [OP_W-1:0] OP_SET  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd2;

  typedef struct packed {
    logic [SC_W-1:0]   free_count;
    logic [STAT_W-1:0] status;
    logic [LINK_W-1:0] link_value;
  } fcta_res_t;

endpackage

/* rtl/fcta_mem.sv */
`timescale 1ns / 1ps

module fcta_mem #(
  parameter int unsigned DEPTH = fcta_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [fcta_pkg::LINK_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [fcta_pkg::LINK_W-1:0] rdata_o
);
  import fcta_pkg::*;

  logic [LINK_W-1:0] mem_q [DEPTH];
  logic [LINK_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fcta_ctrl.sv */
`timescale 1ns / 1ps

module fcta_ctrl #(
  parameter int unsigned TABLE_DEPTH = fcta_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [fcta_pkg::SC_W-1:0]   cfg_data_i,
  output logic                        cfg_ready_o,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  logic [fcta_pkg::OP_W-1:0]   req_op_i,
  input  logic [fcta_pkg::IDX_W-1:0]  req_index_i,
  input  logic [fcta_pkg::LINK_W-1:0] req_link_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output fcta_pkg::fcta_res_t         res_o,
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [fcta_pkg::LINK_W-1:0] mem_wdata_o,
  output logic                        mem_re_o,
  output logic [AW-1:0]               mem_raddr_o,
  input  logic [fcta_pkg::LINK_W-1:0] mem_rdata_i
);
  import fcta_pkg::*;

  localparam int unsigned SC_MAX = (1 << SC_W) - 1;
  localparam int unsigned MAXC   = (TABLE_DEPTH < SC_MAX) ? TABLE_DEPTH : SC_MAX;
  localparam int unsigned CW     = $clog2(MAXC + 1);
  localparam int unsigned UW     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW   = 17;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_ACCESS = 4'b0100,
    S_SEARCH = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [SC_W-1:0]   sc_q;
  logic [UW-1:0]     used_q, used_d;
  logic [CW-1:0]     rover_q;
  logic [OP_W-1:0]   op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [LINK_W-1:0] nl_q;
  logic              inrange_q;
  logic [CW-1:0]     chk_q;
  logic [CW-1:0]     left_q;
  logic [AW-1:0]     clr_q;

  logic [CW-1:0]     cnt;
  logic              req_fire;
  logic              res_fire;
  logic              is_rw_q;
  logic              hit;
  logic              search_done;
  logic [LINK_W-1:0] link_val;
  logic [STAT_W-1:0] stat_val;
  logic [CMPW-1:0]   free_wide;

  function automatic logic [CW-1:0] next_cand(input logic [CW-1:0] c, input logic [CW-1:0] n);
    logic [CW:0] s;
    s = {1'b0, c} + (CW+1)'(1);
    next_cand = (s >= {1'b0, n}) ? CW'(1) : s[CW-1:0];
  endfunction

  // sector count saturated into the table, at least 2
  always_comb begin
    if (CMPW'(sc_q) < CMPW'(2)) begin
      cnt = CW'(2);
    end else if (CMPW'(sc_q) > CMPW'(TABLE_DEPTH)) begin
      cnt = CW'(TABLE_DEPTH);
    end else begin
      cnt = CW'(sc_q);
    end
  end

  assign cfg_ready_o = 1'b1;
  assign req_ready_o = (state_q == S_IDLE);
  assign req_fire    = req_valid_i && req_ready_o;

  assign is_rw_q     = (op_q == OP_READ) || (op_q == OP_SET);
  assign hit         = (mem_rdata_i == '0);
  assign search_done = hit || (left_q == CW'(1));

  assign res_valid_o = (state_q == S_ACCESS) || ((state_q == S_SEARCH) && search_done);
  assign res_fire    = res_valid_o && res_ready_i;

  always_comb begin
    link_val = '0;
    stat_val = STAT_OK;
    used_d   = used_q;
    if (state_q == S_SEARCH) begin
      if (hit) begin
        link_val = LINK_W'(chk_q);
      end else begin
        stat_val = STAT_NOFREE;
      end
    end else if (is_rw_q) begin
      if (!inrange_q) begin
        stat_val = STAT_RANGE;
      end else begin
        link_val = mem_rdata_i;
        if (op_q == OP_SET) begin
          if ((mem_rdata_i == '0) && (nl_q != '0)) begin
            used_d = used_q + UW'(1);
          end else if ((mem_rdata_i != '0) && (nl_q == '0) && (used_q != '0)) begin
            used_d = used_q - UW'(1);
          end
        end
      end
    end
  end

  assign free_wide = (CMPW'(cnt) > CMPW'(used_d)) ? (CMPW'(cnt) - CMPW'(used_d)) : '0;

  assign res_o.link_value = link_val;
  assign res_o.status     = stat_val;
  assign res_o.free_count = free_wide[SC_W-1:0];

  // memory ports
  always_comb begin
    mem_re_o    = 1'b0;
    mem_raddr_o = AW'(next_cand(chk_q, cnt));
    if (state_q == S_IDLE) begin
      mem_re_o    = req_fire;
      mem_raddr_o = (req_op_i == OP_FIND) ? AW'(next_cand(rover_q, cnt)) : AW'(req_index_i);
    end else if (state_q == S_SEARCH) begin
      mem_re_o = !search_done;
    end
  end

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = AW'(idx_q);
    mem_wdata_o = nl_q;
    if (state_q == S_CLEAR) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = clr_q;
      mem_wdata_o = (clr_q == '0) ? LINK_END : '0;
    end else if (state_q == S_ACCESS) begin
      mem_we_o = res_ready_i && (op_q == OP_SET) && inrange_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          state_d = (req_op_i == OP_FIND) ? S_SEARCH : S_ACCESS;
        end
      end
      S_ACCESS, S_SEARCH: begin
        if (res_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      sc_q    <= SECTOR_COUNT_RST;
      used_q  <= UW'(1);
      rover_q <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        sc_q <= cfg_data_i;
      end
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (res_fire) begin
        used_q <= used_d;
        if ((state_q == S_SEARCH) && hit) begin
          rover_q <= chk_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q      <= req_op_i;
      idx_q     <= req_index_i;
      nl_q      <= req_link_i;
      inrange_q <= CMPW'(req_index_i) < CMPW'(cnt);
      chk_q     <= next_cand(rover_q, cnt);
      left_q    <= cnt - CW'(1);
    end else if ((state_q == S_SEARCH) && !search_done) begin
      chk_q  <= next_cand(chk_q, cnt);
      left_q <= left_q - CW'(1);
    end
  end

endmodule

/* rtl/fat_chain_table_allocator_core.sv */
`timescale 1ns / 1ps
// sector link table with next-fit free sector search
// request channel s_axis: tuser carries the op (read link, set link, find free),
// tdata the sector index and the new link; one response per request on m_axis
// with the link value and free count in tdata and the status in tuser
// cfg channel writes the sector count; it is always ready and must only be
// written while no request is in flight
// read and set: one memory read-modify-write, read when the request is taken and
// written in the access state; response registered, no new request meanwhile
// find free: the walk reads one table entry per cycle from the single read port,
// looking at no more entries than the sector count minus one
// reset: the table is swept one entry per cycle over all TABLE_DEPTH entries while
// s_axis_tready stays low; entry 0 is set to the chain end marker
// receiver stall: the response waits in the output register, the next request
// is still taken and its response holds until the output register frees up
module fat_chain_table_allocator_core #(
  parameter int unsigned TABLE_DEPTH = fcta_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fcta_pkg::SC_W-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // sector_index, new_link
  input  logic [31:0]                   s_axis_tdata,
  // op
  input  logic [fcta_pkg::OP_W-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // link_value, free_count
  output logic [31:0]                   m_axis_tdata,
  // status
  output logic [fcta_pkg::STAT_W-1:0]   m_axis_tuser
);
  import fcta_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic              res_valid;
  logic              res_ready;
  fcta_res_t         res;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [LINK_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [LINK_W-1:0] mem_rdata;

  logic              out_valid_q;
  fcta_res_t         out_q;

  fcta_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_op_i    (s_axis_tuser),
    .req_index_i (s_axis_tdata[IDX_W-1:0]),
    .req_link_i  (s_axis_tdata[IDX_W+LINK_W-1:IDX_W]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  fcta_mem #(
    .DEPTH(TABLE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.free_count, out_q.link_value};
  assign m_axis_tuser  = out_q.status;

  a_res_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> m_axis_tvalid)
    else $error("response lost before output register");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !mem_re)
    else $error("table read and write in the same cycle");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && ((res.status == STAT_RANGE) || (res.status == STAT_NOFREE)))
      |-> (res.link_value == '0) && !mem_we)
    else $error("failed request returns a link or writes the table");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import fcta_pkg::*;

  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    bit               is_cfg;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [LINK_W-1:0] arg;
    bit               typed;
    fcta_res_t        want;
  } step_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [SC_W-1:0]   cfg_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;
  logic [OP_W-1:0]   s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;
  logic [STAT_W-1:0] m_axis_tuser;

  logic [LINK_W-1:0] link_mem [DEPTH];
  int unsigned       used_cnt;
  int unsigned       rover;
  int unsigned       sector_cnt;
  fcta_res_t         answer_q [$];
  step_t             dir_q [$];
  int unsigned       mismatch_cnt = 0;
  bit                snd_calm = 1'b0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  fat_chain_table_allocator_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  function automatic int unsigned eff_sectors();
    if (sector_cnt < 2) return 2;
    if (sector_cnt > DEPTH) return DEPTH;
    return sector_cnt;
  endfunction

  // applies one request to the table copy and returns its response
  function automatic fcta_res_t fat_apply(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                          logic [LINK_W-1:0] nl);
    int unsigned       cnt;
    int unsigned       cand;
    int unsigned       n;
    bit                found;
    logic [LINK_W-1:0] old;
    fcta_res_t         r;
    cnt = eff_sectors();
    r = '0;
    case (op)
      OP_READ, OP_SET: begin
        if (idx >= cnt) begin
          r.status = STAT_RANGE;
        end else begin
          old = link_mem[idx];
          r.link_value = old;
          if (op == OP_SET) begin
            link_mem[idx] = nl;
            if (old == '0 && nl != '0) used_cnt++;
            else if (old != '0 && nl == '0 && used_cnt > 0) used_cnt--;
          end
        end
      end
      OP_FIND: begin
        cand = rover;
        found = 1'b0;
        n = 0;
        while (!found && n + 1 < cnt) begin
          cand++;
          if (cand >= cnt) cand = 1;
          if (link_mem[cand] == '0) found = 1'b1;
          n++;
        end
        if (found) begin
          rover = cand;
          r.link_value = LINK_W'(cand);
        end else begin
          r.status = STAT_NOFREE;
        end
      end
      default: begin
      end
    endcase
    r.free_count = (cnt > used_cnt) ? SC_W'(cnt - used_cnt) : '0;
    return r;
  endfunction

  function automatic void dir_row(bit is_cfg, logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                  logic [LINK_W-1:0] arg, bit typed, logic [LINK_W-1:0] w_link,
                                  logic [STAT_W-1:0] w_stat, logic [SC_W-1:0] w_free);
    step_t s;
    s.is_cfg = is_cfg;
    s.op = op;
    s.idx = idx;
    s.arg = arg;
    s.typed = typed;
    s.want.link_value = w_link;
    s.want.status = w_stat;
    s.want.free_count = w_free;
    dir_q.push_back(s);
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic [LINK_W-1:0] link, input bit typed,
                              input fcta_res_t want, output fcta_res_t pred);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) snd_calm = !snd_calm;
    gap = snd_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, link, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    pred = fat_apply(op, idx, link);
    answer_q.push_back(typed ? want : pred);
  endtask

  task automatic write_sector_count(input logic [SC_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    wait (answer_q.size() == 0);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sector_cnt = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned n_req);
    int unsigned       cnt;
    int unsigned       pick;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [LINK_W-1:0] link;
    logic [IDX_W-1:0]  found;
    bit                claim;
    fcta_res_t         pred;
    cnt = eff_sectors();
    claim = 1'b0;
    found = '0;
    repeat (n_req) begin
      pick = $urandom_range(0, 99);
      if (claim && pick < 70) begin
        // allocate the sector that the last search offered
        op = OP_SET;
        idx = found;
        link = ($urandom_range(0, 1) == 0) ? LINK_END : LINK_W'($urandom_range(1, cnt - 1));
      end else begin
        op = (pick < 30) ? OP_SET : (pick < 55) ? OP_READ : (pick < 92) ? OP_FIND : OP_NONE;
        idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, DEPTH - 1))
                                          : IDX_W'($urandom_range(0, cnt - 1));
        pick = $urandom_range(0, 9);
        link = (pick < 3) ? '0 : (pick < 5) ? LINK_END :
               (pick < 7) ? LINK_W'($urandom_range(1, cnt - 1)) : LINK_W'($urandom());
      end
      send_request(op, idx, link, 1'b0, '0, pred);
      claim = (op == OP_FIND && pred.status == STAT_OK);
      found = pred.link_value[IDX_W-1:0];
    end
  endtask

  initial begin : stimulus
    int unsigned counts [$];
    fcta_res_t   pred;
    foreach (link_mem[i]) link_mem[i] = '0;
    link_mem[0] = LINK_END;
    used_cnt = 1;
    rover = 0;
    sector_cnt = SECTOR_COUNT_RST;

    dir_row(0, OP_READ, 0, 0, 1, LINK_END, STAT_OK, 4095);
    dir_row(0, OP_READ, 4095, 0, 1, 0, STAT_OK, 4095);
    dir_row(0, OP_FIND, 0, 0, 1, 1, STAT_OK, 4095);
    dir_row(0, OP_SET, 1, LINK_END, 1, 0, STAT_OK, 4094);
    dir_row(0, OP_FIND, 4095, LINK_END, 0, 0, 0, 0);
    dir_row(0, OP_SET, 4095, 16'h0ABC, 0, 0, 0, 0);
    dir_row(0, OP_SET, 4095, 0, 0, 0, 0, 0);
    dir_row(0, OP_NONE, 4095, LINK_END, 0, 0, 0, 0);
    dir_row(1, OP_READ, 0, 0, 0, 0, 0, 0);
    dir_row(0, OP_READ, 2, 0, 1, 0, STAT_RANGE, 0);
    dir_row(0, OP_SET, 4095, LINK_END, 1, 0, STAT_RANGE, 0);
    dir_row(0, OP_FIND, 0, 0, 1, 0, STAT_NOFREE, 0);
    dir_row(0, OP_SET, 1, 0, 0, 0, 0, 0);
    dir_row(0, OP_FIND, 0, 0, 0, 0, 0, 0);
    dir_row(1, OP_READ, 0, 1, 0, 0, 0, 0);
    dir_row(0, OP_SET, 1, 5, 0, 0, 0, 0);
    dir_row(1, OP_READ, 0, 3, 0, 0, 0, 0);
    dir_row(0, OP_FIND, 0, 0, 0, 0, 0, 0);
    dir_row(1, OP_READ, 0, 8191, 0, 0, 0, 0);
    dir_row(0, OP_SET, 4095, LINK_END, 0, 0, 0, 0);
    dir_row(0, OP_READ, 4095, 0, 0, 0, 0, 0);
    dir_row(0, OP_SET, 0, 0, 0, 0, 0, 0);
    dir_row(0, OP_FIND, 0, 0, 0, 0, 0, 0);
    dir_row(0, OP_SET, 0, LINK_END, 0, 0, 0, 0);
    dir_row(0, OP_SET, 2048, 16'h8001, 0, 0, 0, 0);

    counts = '{0, 1, 2, 3, 5, 17, 8191, 4097, 64, 300, 4096, 8};
    counts.push_back($urandom_range(2, 200));
    counts.push_back($urandom_range(0, 8191));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_q[i]) begin
      if (dir_q[i].is_cfg) begin
        write_sector_count(dir_q[i].arg[SC_W-1:0]);
      end else begin
        send_request(dir_q[i].op, dir_q[i].idx, dir_q[i].arg, dir_q[i].typed,
                     dir_q[i].want, pred);
      end
    end

    foreach (counts[i]) begin
      write_sector_count(SC_W'(counts[i]));
      random_phase(63);
    end

    s_axis_tvalid <= 1'b0;
    wait (answer_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[fat_chain_table_allocator_core] OK");
    end else begin
      $display("[fat_chain_table_allocator_core] ERROR");
    end
    $finish;
  end

  initial begin : resp_check
    int unsigned stall;
    bit          calm;
    fcta_res_t   want;
    calm = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (answer_q.size() == 0) begin
        $display("%0t unexpected response: expected none got link %h status %0d free %0d",
                 $time, m_axis_tdata[LINK_W-1:0], m_axis_tuser, m_axis_tdata[LINK_W +: SC_W]);
        mismatch_cnt++;
      end else begin
        want = answer_q.pop_front();
        if (m_axis_tdata[LINK_W-1:0] !== want.link_value) begin
          $display("%0t link_value expected %h got %h", $time, want.link_value,
                   m_axis_tdata[LINK_W-1:0]);
          mismatch_cnt++;
        end
        if (m_axis_tuser !== want.status) begin
          $display("%0t status expected %0d got %0d", $time, want.status, m_axis_tuser);
          mismatch_cnt++;
        end
        if (m_axis_tdata[LINK_W +: SC_W] !== want.free_count) begin
          $display("%0t free_count expected %0d got %0d", $time, want.free_count,
                   m_axis_tdata[LINK_W +: SC_W]);
          mismatch_cnt++;
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    #200_000_000;
    $display("[fat_chain_table_allocator_core] ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/fcta_pkg.sv
rtl/fcta_mem.sv
rtl/fcta_ctrl.sv
rtl/fat_chain_table_allocator_core.sv
test/testbench.sv
